/* rtl/hdwd_pkg.sv */
// Shared types, constants and helper functions for the Huffman delta word decoder.
package hdwd_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned PAYLOAD_W   = 14;
  localparam int unsigned RAW_W       = 12;
  localparam int unsigned MAX_RUN     = 6;
  localparam int unsigned RUN_W       = 3;
  localparam logic [1:0]  HUFF_HEADER = 2'b10;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_LONG_RUN   = 2'd1,
    ST_BAD_HEADER = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_RAW  = 2'd0,
    KIND_ERR  = 2'd1,
    KIND_HUFF = 2'd2
  } kind_e;

  // One classified item waiting for the back end.
  typedef struct packed {
    kind_e                  kind;
    status_e                status;
    logic [WORD_W-1:0]      sample;  // raw sample, or base value for deltas
    logic [PAYLOAD_W-1:0]   bits;    // Huffman payload, top bit first
  } entry_t;

  // Zeros above the first one bit; 7 when none among the top seven.
  function automatic logic [RUN_W-1:0] lead_zeros(input logic [PAYLOAD_W-1:0] bits);
    logic [RUN_W-1:0] n;
    logic             found;
    n     = RUN_W'(MAX_RUN + 1);
    found = 1'b0;
    for (int i = 0; i <= int'(MAX_RUN); i++) begin
      if (!found && bits[PAYLOAD_W-1-i]) begin
        n     = RUN_W'(i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Delta applied for a zero run of the given length.
  function automatic logic [WORD_W-1:0] run_delta(input logic [RUN_W-1:0] run);
    logic [WORD_W-1:0] d;
    case (run)
      3'd1:    d = 16'hffff;
      3'd2:    d = 16'h0001;
      3'd3:    d = 16'hfffe;
      3'd4:    d = 16'h0002;
      3'd5:    d = 16'hfffd;
      3'd6:    d = 16'h0003;
      default: d = 16'h0000;
    endcase
    return d;
  endfunction

endpackage

/* rtl/hdwd_in_if.sv */
// Input channel: previous sample and compressed code word.
interface hdwd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] previous_sample;
  logic [15:0] code_word;

  modport source (output valid, output previous_sample, output code_word, input ready);
  modport sink   (input valid, input previous_sample, input code_word, output ready);
endinterface

/* rtl/hdwd_out_if.sv */
// Output channel: decoded sample, last flag and status.
interface hdwd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;
  logic [1:0]         status;

  modport source (output valid, output sample, output last, output status, input ready);
  modport sink   (input valid, input sample, input last, input status, output ready);
endinterface

/* rtl/hdwd_front.sv */
// Front end: accepts code words, classifies them and checks for long zero runs.
module hdwd_front (
  hdwd_in_if.sink          in_ch_i,
  input  logic             full_i,
  output logic             push_o,
  output hdwd_pkg::entry_t entry_o
);

  logic [hdwd_pkg::PAYLOAD_W-1:0] payload;
  logic                           is_raw;
  logic                           is_huff;
  logic                           long_run;

  assign payload = in_ch_i.code_word[hdwd_pkg::PAYLOAD_W-1:0];
  assign is_raw  = (in_ch_i.code_word[15:12] == 4'd0);
  assign is_huff = (in_ch_i.code_word[15:14] == hdwd_pkg::HUFF_HEADER);

  // A one bit with seven zeros right above it ends an over-long run.
  always_comb begin
    long_run = 1'b0;
    for (int i = 0; i <= int'(hdwd_pkg::MAX_RUN); i++) begin
      if (payload[i] && (payload[i+1 +: hdwd_pkg::MAX_RUN+1] == '0)) begin
        long_run = 1'b1;
      end
    end
  end

  always_comb begin
    entry_o.sample = in_ch_i.previous_sample;
    entry_o.bits   = payload;
    entry_o.status = hdwd_pkg::ST_OK;
    entry_o.kind   = hdwd_pkg::KIND_HUFF;
    if (is_raw) begin
      entry_o.kind   = hdwd_pkg::KIND_RAW;
      entry_o.sample = {4'd0, in_ch_i.code_word[hdwd_pkg::RAW_W-1:0]};
    end else if (!is_huff) begin
      entry_o.kind   = hdwd_pkg::KIND_ERR;
      entry_o.status = hdwd_pkg::ST_BAD_HEADER;
      entry_o.sample = '0;
    end else if (long_run) begin
      entry_o.kind   = hdwd_pkg::KIND_ERR;
      entry_o.status = hdwd_pkg::ST_LONG_RUN;
      entry_o.sample = '0;
    end
  end

  assign in_ch_i.ready = !full_i;
  // An empty Huffman payload yields nothing and is dropped here.
  assign push_o = in_ch_i.valid && !full_i && !(is_huff && !is_raw && payload == '0);

endmodule

/* rtl/hdwd_fifo.sv */
// Small queue of classified items between front and back end.
module hdwd_fifo #(
  parameter int unsigned Depth = hdwd_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hdwd_pkg::entry_t push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output hdwd_pkg::entry_t pop_entry_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hdwd_pkg::entry_t slots_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o      = (cnt_q == CntW'(Depth));
  assign empty_o     = (cnt_q == '0);
  assign pop_entry_o = slots_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_entry_i;
    end
  end

endmodule

/* rtl/hdwd_back.sv */
// Back end: walks Huffman payloads one run per cycle, while the output register is free, into the output register.
module hdwd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  hdwd_pkg::entry_t entry_i,
  output logic             pop_o,
  hdwd_out_if.source       out_ch_o
);

  logic                           busy_q, busy_d;
  logic [hdwd_pkg::PAYLOAD_W-1:0] rem_q, rem_d;
  logic [hdwd_pkg::WORD_W-1:0]    run_q, run_d;
  logic                           out_valid_q, out_valid_d;
  logic [hdwd_pkg::WORD_W-1:0]    sample_q, sample_d;
  logic                           last_q, last_d;
  logic [1:0]                     status_q, status_d;

  logic                           out_free;
  logic [hdwd_pkg::PAYLOAD_W-1:0] cur_bits;
  logic [hdwd_pkg::WORD_W-1:0]    cur_run;
  logic [hdwd_pkg::RUN_W-1:0]     lz;
  logic [hdwd_pkg::PAYLOAD_W-1:0] next_bits;
  logic [hdwd_pkg::WORD_W-1:0]    next_run;

  assign out_free = !out_valid_q || out_ch_o.ready;
  assign pop_o    = !busy_q && !empty_i && out_free;

  assign cur_bits  = busy_q ? rem_q : entry_i.bits;
  assign cur_run   = busy_q ? run_q : entry_i.sample;
  assign lz        = hdwd_pkg::lead_zeros(cur_bits);
  assign next_bits = cur_bits << ({1'b0, lz} + 4'd1);
  assign next_run  = cur_run + hdwd_pkg::run_delta(lz);

  always_comb begin
    busy_d      = busy_q;
    rem_d       = rem_q;
    run_d       = run_q;
    out_valid_d = out_valid_q && !out_ch_o.ready;
    sample_d    = sample_q;
    last_d      = last_q;
    status_d    = status_q;
    if (busy_q && out_free) begin
      out_valid_d = 1'b1;
      sample_d    = next_run;
      last_d      = (next_bits == '0);
      status_d    = hdwd_pkg::ST_OK;
      rem_d       = next_bits;
      run_d       = next_run;
      busy_d      = (next_bits != '0);
    end else if (pop_o) begin
      out_valid_d = 1'b1;
      if (entry_i.kind == hdwd_pkg::KIND_HUFF) begin
        sample_d = next_run;
        last_d   = (next_bits == '0);
        status_d = hdwd_pkg::ST_OK;
        rem_d    = next_bits;
        run_d    = next_run;
        busy_d   = (next_bits != '0);
      end else begin
        sample_d = entry_i.sample;
        last_d   = 1'b1;
        status_d = entry_i.status;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    run_q    <= run_d;
    sample_q <= sample_d;
    last_q   <= last_d;
    status_q <= status_d;
  end

  assign out_ch_o.valid  = out_valid_q;
  assign out_ch_o.sample = $signed(sample_q);
  assign out_ch_o.last   = last_q;
  assign out_ch_o.status = status_q;

  a_busy_has_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q != '0)
    else $error("busy with an exhausted payload");

  a_no_long_run_here: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q || (pop_o && entry_i.kind == hdwd_pkg::KIND_HUFF)) |->
      lz <= hdwd_pkg::RUN_W'(hdwd_pkg::MAX_RUN))
    else $error("over-long run reached the back end");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != hdwd_pkg::ST_OK) |-> last_q && sample_q == '0)
    else $error("error result not alone");

  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && out_free && last_d) |=> !busy_q)
    else $error("payload walk did not end after last sample");

endmodule

/* rtl/huffman_delta_word_decoder_top.sv */
// Top level of the Huffman delta word decoder.
//
//   channel   dir  payload                          handshake
//   in_ch_i   in   previous_sample[16] code_word[16] valid/ready
//   out_ch_o  out  sample[16,s] last[1] status[2]    valid/ready
//
// A raw, bad-header or long-run word gives one result from the back end.
// A Huffman word gives up to 14 samples, one per cycle while the output is not stalled, set by the run walker.
// Words with an empty payload are dropped in the front end and give nothing.
// Front and back are split by a queue, so words are taken while results stall, until the queue is full.
// Reset clears queue pointers, the walker busy flag and output valid; no clearing pass.
module huffman_delta_word_decoder_top #(
  parameter int unsigned QueueDepth = hdwd_pkg::QUEUE_DEPTH
) (
  input logic        clk_i,
  input logic        rst_ni,
  hdwd_in_if.sink    in_ch_i,
  hdwd_out_if.source out_ch_o
);

  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  hdwd_pkg::entry_t push_entry;
  hdwd_pkg::entry_t pop_entry;

  hdwd_front u_front (
    .in_ch_i (in_ch_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  hdwd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry),
    .empty_o      (empty)
  );

  hdwd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .entry_i  (pop_entry),
    .pop_o    (pop),
    .out_ch_o (out_ch_o)
  );

endmodule
